// ===== hw/rtl/byte_stream_substring_search_core_macros.svh =====
// Assertion macros for the substring search core.
`ifndef BYTE_STREAM_SUBSTRING_SEARCH_CORE_MACROS_SVH
`define BYTE_STREAM_SUBSTRING_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BSSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define BSSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bsss_pkg.sv =====
package bsss_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int POS_BITS    = 16;

    localparam int LEN_W     = 5;
    localparam int PAT_BYTES = 16;
    localparam int WIN_DEPTH = MAX_PATTERN - 1;
    localparam int IDX_W     = $clog2(MAX_PATTERN);
    localparam int CNT_W     = POS_BITS + 1;
    localparam int POS_W     = 16;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 64;

    localparam logic [CNT_W-1:0] POS_LIMIT = CNT_W'(1) << POS_BITS;
    localparam logic [CNT_W-1:0] COUNT_CAP = POS_LIMIT + CNT_W'(MAX_PATTERN);

    typedef enum logic [1:0] {
        REG_PATTERN_LEN  = 2'd0,
        REG_PATTERN_LOW  = 2'd1,
        REG_PATTERN_HIGH = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0]          pattern_len;
        logic [PAT_BYTES-1:0][7:0] pattern;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             overflow;
    } res_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = len;
        if (len > LEN_W'(MAX_PATTERN))
        begin
            r = LEN_W'(MAX_PATTERN);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bsss_if.sv =====
interface bsss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bsss_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] position;
    logic        overflow;

    modport source (output valid, output found, output position, output overflow,
                    input ready);
    modport sink   (input valid, input found, input position, input overflow,
                    output ready);
endinterface

// ===== hw/rtl/bsss_cfg.sv =====
module bsss_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsss_pkg::ADDR_W-1:0]   paddr,
    input  logic [bsss_pkg::DATA_W-1:0]   pwdata,
    output logic [bsss_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output bsss_pkg::cfg_t                cfg
);
    import bsss_pkg::*;

    logic [LEN_W-1:0] len_reg, len_next;
    logic [63:0]      low_reg, low_next;
    logic [63:0]      high_reg, high_next;
    logic             wr_en;
    reg_idx_t         reg_sel;

    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign pready  = 1'b1;

    always_comb
    begin
        len_next  = len_reg;
        low_next  = low_reg;
        high_next = high_reg;
        prdata    = '0;
        unique case (reg_sel)
            REG_PATTERN_LEN:
            begin
                prdata = DATA_W'(len_reg);
                if (wr_en)
                begin
                    len_next = pwdata[LEN_W-1:0];
                end
            end
            REG_PATTERN_LOW:
            begin
                prdata = low_reg;
                if (wr_en)
                begin
                    low_next = pwdata;
                end
            end
            REG_PATTERN_HIGH:
            begin
                prdata = high_reg;
                if (wr_en)
                begin
                    high_next = pwdata;
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            low_reg  <= '0;
            high_reg <= '0;
        end
        else
        begin
            len_reg  <= len_next;
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign cfg.pattern_len = len_reg;
    assign cfg.pattern     = {high_reg, low_reg};

endmodule

// ===== hw/rtl/bsss_match.sv =====
module bsss_match (
    input  logic           clk,
    input  logic           rst_n,
    input  bsss_pkg::cfg_t cfg,
    input  logic           item_fire,
    input  bsss_pkg::item_t item,
    input  logic           res_ready,
    output logic           res_valid,
    output bsss_pkg::res_t res,
    output logic           res_free
);
    import bsss_pkg::*;

    logic [7:0]          win_reg [WIN_DEPTH];
    logic [7:0]          win_next [WIN_DEPTH];
    logic [CNT_W-1:0]    cnt_reg, cnt_next, cnt_upd, cnt_plus, start;
    logic                seen_reg, seen_next, seen_upd;
    logic [POS_BITS-1:0] mstart_reg, mstart_next, mstart_upd;
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg, res_next;
    logic [LEN_W-1:0]    len;
    logic [7:0]          cand [MAX_PATTERN];
    logic                eq, in_range, hit;
    logic [31:0]         pos_wide;

    assign len      = clamp_len(cfg.pattern_len);
    assign cnt_plus = cnt_reg + CNT_W'(1);
    assign start    = cnt_plus - CNT_W'(len);
    assign in_range = (len != '0) && (cnt_plus >= CNT_W'(len)) && (cnt_reg < COUNT_CAP);

    always_comb
    begin
        cand[0] = item.data_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            cand[k] = win_reg[k-1];
        end
    end

    always_comb
    begin
        logic [IDX_W-1:0] pidx;
        eq = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            pidx = IDX_W'(len - LEN_W'(1) - LEN_W'(k));
            if ((LEN_W'(k) < len) && (cfg.pattern[pidx] != cand[k]))
            begin
                eq = 1'b0;
            end
        end
    end

    assign hit        = in_range && eq && !seen_reg && (start < POS_LIMIT);
    assign seen_upd   = seen_reg | hit;
    assign mstart_upd = hit ? start[POS_BITS-1:0] : mstart_reg;
    assign cnt_upd    = (cnt_reg < COUNT_CAP) ? cnt_plus : cnt_reg;
    assign pos_wide   = 32'(mstart_upd);
    assign res_free   = !res_valid_reg || res_ready;

    always_comb
    begin
        win_next       = win_reg;
        cnt_next       = cnt_reg;
        seen_next      = seen_reg;
        mstart_next    = mstart_reg;
        res_valid_next = res_valid_reg & ~res_ready;
        res_next       = res_reg;
        if (item_fire)
        begin
            if (item.last_byte)
            begin
                for (int k = 0; k < WIN_DEPTH; k++)
                begin
                    win_next[k] = '0;
                end
                cnt_next          = '0;
                seen_next         = 1'b0;
                mstart_next       = '0;
                res_valid_next    = 1'b1;
                res_next.found    = (len == '0) ? 1'b1 : seen_upd;
                res_next.position = ((len != '0) && seen_upd) ? pos_wide[POS_W-1:0] : '0;
                res_next.overflow = cnt_upd > POS_LIMIT;
            end
            else
            begin
                win_next[0] = item.data_byte;
                for (int k = 1; k < WIN_DEPTH; k++)
                begin
                    win_next[k] = win_reg[k-1];
                end
                cnt_next    = cnt_upd;
                seen_next   = seen_upd;
                mstart_next = mstart_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_DEPTH; k++)
            begin
                win_reg[k] <= '0;
            end
            cnt_reg       <= '0;
            seen_reg      <= 1'b0;
            mstart_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            cnt_reg       <= cnt_next;
            seen_reg      <= seen_next;
            mstart_reg    <= mstart_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/byte_stream_substring_search_core.sv =====
// Channel      Dir  Payload                       Handshake
// data_in      in   data_byte[7:0], last_byte     valid/ready
// result_out   out  found, position[15:0],        valid/ready
//                   overflow
// apb          in   pattern_len @0x00, pattern_low @0x08, pattern_high @0x10
//
// One request per cycle unless a result is held; results pass the input and result registers.
// Throughput is set by the single compare stage between the input and result registers.
// Reset clears the pattern registers, the window, the byte count and the match state.
// A held result stalls the compare stage; data_in stays ready while the input register drains.
module byte_stream_substring_search_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsss_pkg::ADDR_W-1:0]   paddr,
    input  logic [bsss_pkg::DATA_W-1:0]   pwdata,
    output logic [bsss_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    bsss_in_if.sink                       data_in,
    bsss_out_if.source                    result_out
);
    import bsss_pkg::*;

    cfg_t  cfg;
    item_t item_reg, item_next;
    logic  item_valid_reg, item_valid_next;
    logic  accept, item_fire, res_free, res_valid;
    res_t  res;

    bsss_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign item_fire     = item_valid_reg && res_free;
    assign data_in.ready = !item_valid_reg || res_free;
    assign accept        = data_in.valid && data_in.ready;

    always_comb
    begin
        item_next       = item_reg;
        item_valid_next = item_valid_reg & ~item_fire;
        if (accept)
        begin
            item_next.data_byte = data_in.data_byte;
            item_next.last_byte = data_in.last_byte;
            item_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    bsss_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .item_fire (item_fire),
        .item      (item_reg),
        .res_ready (result_out.ready),
        .res_valid (res_valid),
        .res       (res),
        .res_free  (res_free)
    );

    assign result_out.valid    = res_valid;
    assign result_out.found    = res.found;
    assign result_out.position = res.position;
    assign result_out.overflow = res.overflow;

endmodule

// ===== hw/rtl/bsss_checker.sv =====
`include "byte_stream_substring_search_core_macros.svh"

module bsss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        found,
    input logic [15:0] position,
    input logic        overflow
);

    `BSSS_ASSERT_NEXT(a_res_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(found) && $stable(position) && $stable(overflow), "result changed while stalled")

    `BSSS_ASSERT_NOW(a_miss_pos_zero, clk, rst_n, out_valid && !found, position == 16'd0, "position nonzero without a match")

    `BSSS_ASSERT_NOW(a_ready_when_drained, clk, rst_n, !out_valid, in_ready, "input stalled with no result pending")

    `BSSS_ASSERT_NEXT(a_valid_hold, clk, rst_n, in_valid && !in_ready, in_valid, "request dropped while stalled")

endmodule

bind byte_stream_substring_search_core bsss_checker u_bsss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (data_in.valid),
    .in_ready  (data_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .found     (result_out.found),
    .position  (result_out.position),
    .overflow  (result_out.overflow)
);
